FILE: hdl/awir_pkg.sv
// package with shared constants, types and the controller state encoding
package awir_pkg;

    localparam int unsigned DEF_MAX_SRC_WIDTH  = 64;
    localparam int unsigned DEF_MAX_SRC_HEIGHT = 64;
    localparam int unsigned DEF_CHANNELS       = 4;
    localparam int unsigned DEF_SAMPLE_BITS    = 16;

    localparam int unsigned SRC_SZ_W = 7;
    localparam int unsigned DST_SZ_W = 9;
    localparam int unsigned COORD_W  = 16;
    localparam int unsigned POS_W    = 17;
    localparam int unsigned WT_W     = 7;
    localparam int unsigned W_W      = 14;
    localparam int unsigned AREA_W   = 14;
    localparam int unsigned PORT_SAMPLE_W = 16;
    localparam int unsigned PORT_CH  = 4;

    localparam logic       OP_STORE   = 1'b0;
    localparam logic       OP_COMPUTE = 1'b1;

    localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [1:0] REG_DST_WIDTH  = 2'd2;
    localparam logic [1:0] REG_DST_HEIGHT = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_DSTART,
        S_DWAIT,
        S_CHK,
        S_RD,
        S_ACC,
        S_ASTART,
        S_AWAIT,
        S_OUT
    } awir_state_t;

    typedef struct packed {
        logic clr;
        logic acc;
        logic div_start;
    } lane_ctrl_t;

endpackage

FILE: hdl/awir_div.sv
// restoring divider, one quotient bit per cycle
module awir_div import awir_pkg::*; #(
    parameter int unsigned NUM_W = 16,
    parameter int unsigned DEN_W = 9
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo,
    output logic [DEN_W-1:0] rem
);

    localparam int unsigned CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W:0]   shifted;
    logic             fits;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[NUM_W-1]};
        fits      = shifted >= {1'b0, den};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            quo_next  = num;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DEN_W'(shifted - {1'b0, den}) : shifted[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

FILE: hdl/awir_lane.sv
// one channel lane: weighted accumulate and divide by the footprint area
module awir_lane import awir_pkg::*; #(
    parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lane_ctrl_t             ctrl,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic [W_W-1:0]         weight,
    input  logic [AREA_W-1:0]      area,
    output logic                   done,
    output logic [SAMPLE_BITS-1:0] avg
);

    localparam int unsigned ACC_W = SAMPLE_BITS + W_W;

    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [ACC_W-1:0]  quo;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clr)
            acc_next = '0;
        else if (ctrl.acc)
            acc_next = acc_reg + ACC_W'(ACC_W'(sample) * ACC_W'(weight));
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    awir_div #(
        .NUM_W (ACC_W),
        .DEN_W (AREA_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctrl.div_start),
        .num   (acc_reg),
        .den   (area),
        .done  (done),
        .quo   (quo),
        .rem   ()
    );

    assign avg = quo[SAMPLE_BITS-1:0];

endmodule

FILE: hdl/area_weighted_image_resampler_unit.sv
// top level: source image store, footprint sequencer, channel lanes and result merge
// store item: accepted in S_IDLE and written to the image memory at once
// compute item: 4 parallel 16-step coordinate dividers find the overlapped source pixels, each
// of which is read (S_RD) and accumulated (S_ACC) through the memory port, then one bit-serial
// area divider per lane; one item in flight at a time
// reset: sizes return to 64x64 source and 32x32 destination, image content undefined
module area_weighted_image_resampler_unit import awir_pkg::*; #(
    parameter int unsigned MAX_SRC_WIDTH  = DEF_MAX_SRC_WIDTH,
    parameter int unsigned MAX_SRC_HEIGHT = DEF_MAX_SRC_HEIGHT,
    parameter int unsigned CHANNELS       = DEF_CHANNELS,
    parameter int unsigned SAMPLE_BITS    = DEF_SAMPLE_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [DST_SZ_W-1:0] cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                opcode,
    input  logic [5:0]          src_x,
    input  logic [5:0]          src_y,
    input  logic [7:0]          dst_x,
    input  logic [7:0]          dst_y,
    input  logic [15:0]         channel_0,
    input  logic [15:0]         channel_1,
    input  logic [15:0]         channel_2,
    input  logic [15:0]         channel_3,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [15:0]         result_0,
    output logic [15:0]         result_1,
    output logic [15:0]         result_2,
    output logic [15:0]         result_3
);

    localparam int unsigned DEPTH  = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned WORD_W = CHANNELS * SAMPLE_BITS;
    localparam int unsigned SW_CAP = (MAX_SRC_WIDTH > 127) ? 127 : MAX_SRC_WIDTH;
    localparam int unsigned SH_CAP = (MAX_SRC_HEIGHT > 127) ? 127 : MAX_SRC_HEIGHT;

    awir_state_t state_reg, state_next;

    logic [SRC_SZ_W-1:0] src_width_reg, src_height_reg;
    logic [DST_SZ_W-1:0] dst_width_reg, dst_height_reg;
    logic [SRC_SZ_W-1:0] sw, sh;
    logic [DST_SZ_W-1:0] dw, dh;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] mem_q_reg;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic              wr_en;
    logic [WORD_W-1:0] wr_word;
    logic [15:0]       in_ch [PORT_CH];

    logic [7:0]        dx_reg, dy_reg;
    logic [COORD_W-1:0] left_reg, top_reg, right_w, bottom_w;
    logic [AREA_W-1:0] area_reg;
    logic              dstart;
    logic              d_done;
    logic [COORD_W-1:0] q_x0, q_x1, q_y0, q_y1;
    logic [DST_SZ_W-1:0] r_x0, r_y0;
    logic [COORD_W-1:0] x0_reg, x1_reg, y0_reg, y1_reg;
    logic [COORD_W-1:0] ox_reg, oy_reg;
    logic [POS_W-1:0]  px0_reg, py0_reg, px_reg, py_reg;
    logic [POS_W-1:0]  px_hi, py_hi, lo_x, hi_x, lo_y, hi_y;
    logic [WT_W-1:0]   wx, wy;
    logic [W_W-1:0]    w_reg;
    logic              last_x, last_y, empty;

    lane_ctrl_t        lctrl;
    logic [CHANNELS-1:0] lane_done;
    logic [SAMPLE_BITS-1:0] lane_avg [CHANNELS];
    logic              out_valid_reg, out_valid_next;
    logic [15:0]       res_reg [PORT_CH];
    logic              load_out;

    assign sw = (src_width_reg == '0) ? SRC_SZ_W'(1) :
                (src_width_reg > SRC_SZ_W'(SW_CAP)) ? SRC_SZ_W'(SW_CAP) : src_width_reg;
    assign sh = (src_height_reg == '0) ? SRC_SZ_W'(1) :
                (src_height_reg > SRC_SZ_W'(SH_CAP)) ? SRC_SZ_W'(SH_CAP) : src_height_reg;
    assign dw = (dst_width_reg == '0) ? DST_SZ_W'(1) : dst_width_reg;
    assign dh = (dst_height_reg == '0) ? DST_SZ_W'(1) : dst_height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= SRC_SZ_W'(64);
            src_height_reg <= SRC_SZ_W'(64);
            dst_width_reg  <= DST_SZ_W'(32);
            dst_height_reg <= DST_SZ_W'(32);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SRC_WIDTH:  src_width_reg  <= cfg_data[SRC_SZ_W-1:0];
                REG_SRC_HEIGHT: src_height_reg <= cfg_data[SRC_SZ_W-1:0];
                REG_DST_WIDTH:  dst_width_reg  <= cfg_data;
                REG_DST_HEIGHT: dst_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // image memory
    assign in_ch[0] = channel_0;
    assign in_ch[1] = channel_1;
    assign in_ch[2] = channel_2;
    assign in_ch[3] = channel_3;

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
            wr_word[c*SAMPLE_BITS +: SAMPLE_BITS] = in_ch[c][SAMPLE_BITS-1:0];
    end

    assign wr_en   = in_valid && !in_stall && (opcode == OP_STORE) &&
                     (32'(src_x) < MAX_SRC_WIDTH) && (32'(src_y) < MAX_SRC_HEIGHT);
    assign wr_addr = ADDR_W'(32'(src_y) * MAX_SRC_WIDTH + 32'(src_x));
    assign rd_addr = ADDR_W'(32'(oy_reg) * MAX_SRC_WIDTH + 32'(ox_reg));

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_word;
        mem_q_reg <= mem[rd_addr];
    end

    // footprint bounds
    assign right_w  = left_reg + COORD_W'(sw);
    assign bottom_w = top_reg + COORD_W'(sh);

    awir_div #(.NUM_W(COORD_W), .DEN_W(DST_SZ_W)) u_div_x0 (
        .clk(clk), .rst_n(rst_n), .start(dstart), .num(left_reg), .den(dw),
        .done(d_done), .quo(q_x0), .rem(r_x0)
    );

    awir_div #(.NUM_W(COORD_W), .DEN_W(DST_SZ_W)) u_div_x1 (
        .clk(clk), .rst_n(rst_n), .start(dstart),
        .num(right_w + COORD_W'(dw) - COORD_W'(1)), .den(dw),
        .done(), .quo(q_x1), .rem()
    );

    awir_div #(.NUM_W(COORD_W), .DEN_W(DST_SZ_W)) u_div_y0 (
        .clk(clk), .rst_n(rst_n), .start(dstart), .num(top_reg), .den(dh),
        .done(), .quo(q_y0), .rem(r_y0)
    );

    awir_div #(.NUM_W(COORD_W), .DEN_W(DST_SZ_W)) u_div_y1 (
        .clk(clk), .rst_n(rst_n), .start(dstart),
        .num(bottom_w + COORD_W'(dh) - COORD_W'(1)), .den(dh),
        .done(), .quo(q_y1), .rem()
    );

    // overlap weights
    assign px_hi = px_reg + POS_W'(dw);
    assign py_hi = py_reg + POS_W'(dh);
    assign lo_x  = (px_reg > POS_W'(left_reg)) ? px_reg : POS_W'(left_reg);
    assign hi_x  = (px_hi < POS_W'(right_w)) ? px_hi : POS_W'(right_w);
    assign lo_y  = (py_reg > POS_W'(top_reg)) ? py_reg : POS_W'(top_reg);
    assign hi_y  = (py_hi < POS_W'(bottom_w)) ? py_hi : POS_W'(bottom_w);
    assign wx    = (hi_x > lo_x) ? WT_W'(hi_x - lo_x) : '0;
    assign wy    = (hi_y > lo_y) ? WT_W'(hi_y - lo_y) : '0;

    assign last_x = (ox_reg + COORD_W'(1)) >= x1_reg;
    assign last_y = (oy_reg + COORD_W'(1)) >= y1_reg;
    assign empty  = (x0_reg >= x1_reg) || (y0_reg >= y1_reg);

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                dx_reg <= dst_x;
                dy_reg <= dst_y;
            end
            S_MUL:
            begin
                left_reg <= COORD_W'(COORD_W'(dx_reg) * COORD_W'(sw));
                top_reg  <= COORD_W'(COORD_W'(dy_reg) * COORD_W'(sh));
                area_reg <= AREA_W'(AREA_W'(sw) * AREA_W'(sh));
            end
            S_DWAIT:
            begin
                x0_reg  <= q_x0;
                y0_reg  <= q_y0;
                x1_reg  <= (q_x1 > COORD_W'(sw)) ? COORD_W'(sw) : q_x1;
                y1_reg  <= (q_y1 > COORD_W'(sh)) ? COORD_W'(sh) : q_y1;
                px0_reg <= POS_W'(left_reg - COORD_W'(r_x0));
                py0_reg <= POS_W'(top_reg - COORD_W'(r_y0));
            end
            S_CHK:
            begin
                ox_reg <= x0_reg;
                oy_reg <= y0_reg;
                px_reg <= px0_reg;
                py_reg <= py0_reg;
            end
            S_RD:
            begin
                w_reg <= W_W'(W_W'(wx) * W_W'(wy));
            end
            S_ACC:
            begin
                if (!last_x)
                begin
                    ox_reg <= ox_reg + COORD_W'(1);
                    px_reg <= px_reg + POS_W'(dw);
                end
                else
                begin
                    ox_reg <= x0_reg;
                    px_reg <= px0_reg;
                    oy_reg <= oy_reg + COORD_W'(1);
                    py_reg <= py_reg + POS_W'(dh);
                end
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        dstart     = 1'b0;
        lctrl      = '0;
        load_out   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid && opcode == OP_COMPUTE)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                lctrl.clr  = 1'b1;
                state_next = S_DSTART;
            end
            S_DSTART:
            begin
                dstart     = 1'b1;
                state_next = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (d_done)
                    state_next = S_CHK;
            end
            S_CHK:
            begin
                state_next = empty ? S_ASTART : S_RD;
            end
            S_RD:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                lctrl.acc  = 1'b1;
                state_next = (last_x && last_y) ? S_ASTART : S_RD;
            end
            S_ASTART:
            begin
                lctrl.div_start = 1'b1;
                state_next      = S_AWAIT;
            end
            S_AWAIT:
            begin
                if (lane_done[0])
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // channel lanes
    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_lane
        awir_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctrl   (lctrl),
            .sample (mem_q_reg[c*SAMPLE_BITS +: SAMPLE_BITS]),
            .weight (w_reg),
            .area   (area_reg),
            .done   (lane_done[c]),
            .avg    (lane_avg[c])
        );
    end

    // result merge and output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            for (int c = 0; c < PORT_CH; c++)
            begin
                if (c < CHANNELS)
                    res_reg[c] <= PORT_SAMPLE_W'(lane_avg[c]);
                else
                    res_reg[c] <= '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign result_0  = res_reg[0];
    assign result_1  = res_reg[1];
    assign result_2  = res_reg[2];
    assign result_3  = res_reg[3];

endmodule

FILE: dv/awir_checker.sv
// checker: watches the channels, predicts area-weighted averages and compares results
module awir_checker import awir_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        opcode,
    input  logic [5:0]  src_x,
    input  logic [5:0]  src_y,
    input  logic [7:0]  dst_x,
    input  logic [7:0]  dst_y,
    input  logic [15:0] channel_0,
    input  logic [15:0] channel_1,
    input  logic [15:0] channel_2,
    input  logic [15:0] channel_3,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [15:0] result_0,
    input  logic [15:0] result_1,
    input  logic [15:0] result_2,
    input  logic [15:0] result_3,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [3:0][15:0] pixel_t;

    pixel_t      image_mem [4096];
    logic [6:0]  src_w_reg, src_h_reg;
    logic [8:0]  dst_w_reg, dst_h_reg;
    pixel_t      expected_pixels [$];

    function automatic longint unsigned clamp_size(longint unsigned v, longint unsigned hi);
        if (v == 0)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic longint unsigned span_overlap(longint unsigned a, longint unsigned b,
                                                     longint unsigned l, longint unsigned r);
        longint unsigned lo, hi;
        lo = (a > l) ? a : l;
        hi = (b < r) ? b : r;
        return (hi > lo) ? hi - lo : 0;
    endfunction

    function automatic pixel_t average_footprint(logic [7:0] dx, logic [7:0] dy);
        longint unsigned sw, sh, dw, dh, left, top, x_lo, x_hi, y_lo, y_hi, wy, wt;
        longint unsigned sums [4];
        pixel_t          res;
        pixel_t          px;
        sw = clamp_size(src_w_reg, 64);
        sh = clamp_size(src_h_reg, 64);
        dw = clamp_size(dst_w_reg, 511);
        dh = clamp_size(dst_h_reg, 511);
        left = dx * sw;
        top  = dy * sh;
        x_lo = left / dw;
        x_hi = (left + sw + dw - 1) / dw;
        if (x_hi > sw)
            x_hi = sw;
        y_lo = top / dh;
        y_hi = (top + sh + dh - 1) / dh;
        if (y_hi > sh)
            y_hi = sh;
        for (int c = 0; c < 4; c++)
            sums[c] = 0;
        for (longint unsigned oy = y_lo; oy < y_hi; oy++)
        begin
            wy = span_overlap(oy * dh, oy * dh + dh, top, top + sh);
            for (longint unsigned ox = x_lo; ox < x_hi; ox++)
            begin
                wt = span_overlap(ox * dw, ox * dw + dw, left, left + sw) * wy;
                px = image_mem[(oy * 64 + ox) % 4096];
                for (int c = 0; c < 4; c++)
                    sums[c] += px[c] * wt;
            end
        end
        for (int c = 0; c < 4; c++)
            res[c] = 16'(sums[c] / (sw * sh));
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch on %s: got %0h, expected %0h", what, got, want);
        fail_count++;
    endtask

    assign pending = expected_pixels.size();

    always @(posedge clk or negedge rst_n)
    begin
        pixel_t got, want;
        if (!rst_n)
        begin
            src_w_reg = 64;
            src_h_reg = 64;
            dst_w_reg = 32;
            dst_h_reg = 32;
            expected_pixels.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SRC_WIDTH:  src_w_reg = cfg_data[6:0];
                    REG_SRC_HEIGHT: src_h_reg = cfg_data[6:0];
                    REG_DST_WIDTH:  dst_w_reg = cfg_data;
                    REG_DST_HEIGHT: dst_h_reg = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                got = {result_3, result_2, result_1, result_0};
                if (expected_pixels.size() == 0)
                    report_mismatch("unexpected result", got, 0);
                else
                begin
                    want = expected_pixels.pop_front();
                    for (int c = 0; c < 4; c++)
                        if (got[c] !== want[c])
                            report_mismatch($sformatf("result_%0d", c), got[c], want[c]);
                end
            end
            if (in_valid && !in_stall)
            begin
                if (opcode == OP_STORE)
                    image_mem[{src_y, src_x}] = {channel_3, channel_2, channel_1, channel_0};
                else
                    expected_pixels.push_back(average_footprint(dst_x, dst_y));
            end
        end
    end

    initial
        fail_count = 0;
endmodule

FILE: dv/tb.sv
// testbench top: clock, reset, stimulus for the resampler and the final verdict
module tb;
    import awir_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3000000;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 0;
    logic [8:0]  cfg_data = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic        opcode = OP_STORE;
    logic [5:0]  src_x = 0, src_y = 0;
    logic [7:0]  dst_x = 0, dst_y = 0;
    logic [15:0] channel_0 = 0, channel_1 = 0, channel_2 = 0, channel_3 = 0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [15:0] result_0, result_1, result_2, result_3;
    int          fail_count, pending;
    int          cycles = 0;
    bit          calm = 0;

    always #10 clk = ~clk;

    area_weighted_image_resampler_unit dut (.*);
    awir_checker chk (.*);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(negedge clk)
        out_stall = !calm && ($urandom_range(0, 99) < 8);

    task automatic send_item(logic op, logic [5:0] sx, logic [5:0] sy, logic [7:0] dx,
                             logic [7:0] dy, logic [63:0] samples);
        if (!calm && $urandom_range(0, 99) < 8)
            repeat ($urandom_range(1, 5)) @(negedge clk);
        opcode = op;
        src_x = sx;
        src_y = sy;
        dst_x = dx;
        dst_y = dy;
        {channel_3, channel_2, channel_1, channel_0} = samples;
        in_valid = 1;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        in_valid = 0;
    endtask

    function automatic logic [63:0] rand_samples();
        return {$urandom(), $urandom()};
    endfunction

    task automatic drain();
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [8:0] val);
        drain();
        repeat (100) @(negedge clk);
        cfg_index = idx;
        cfg_data = val;
        cfg_valid = 1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 0;
    endtask

    task automatic set_sizes(int sw, int sh, int dw, int dh);
        write_reg(REG_SRC_WIDTH, 9'(sw));
        write_reg(REG_SRC_HEIGHT, 9'(sh));
        write_reg(REG_DST_WIDTH, 9'(dw));
        write_reg(REG_DST_HEIGHT, 9'(dh));
    endtask

    task automatic compute(logic [7:0] dx, logic [7:0] dy);
        send_item(OP_COMPUTE, 6'($urandom()), 6'($urandom()), dx, dy, rand_samples());
    endtask

    task automatic random_phase(int n, bit hold_once);
        int dw, dh, lim_x, lim_y;
        dw = $urandom_range(8, 511);
        dh = $urandom_range(8, 511);
        set_sizes($urandom_range(0, 16), $urandom_range(0, 16), dw, dh);
        lim_x = (dw > 256) ? 255 : dw - 1;
        lim_y = (dh > 256) ? 255 : dh - 1;
        for (int i = 0; i < n; i++)
        begin
            if (hold_once && i == n / 2)
                drain();
            if ($urandom_range(0, 3) == 0)
                send_item(OP_STORE, 6'($urandom()), 6'($urandom()), 8'($urandom()),
                          8'($urandom()), rand_samples());
            else if ($urandom_range(0, 99) < 85)
                compute(8'($urandom_range(0, lim_x)), 8'($urandom_range(0, lim_y)));
            else
                compute(8'($urandom()), 8'($urandom()));
        end
    endtask

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // written region: 16x16 corner, all of row 0 and all of column 0
        for (int y = 0; y < 16; y++)
            for (int x = 0; x < 16; x++)
                send_item(OP_STORE, 6'(x), 6'(y), 8'($urandom()), 8'($urandom()),
                          rand_samples());
        for (int x = 16; x < 64; x++)
            send_item(OP_STORE, 6'(x), 6'd0, 8'($urandom()), 8'($urandom()),
                      rand_samples());
        for (int y = 16; y < 64; y++)
            send_item(OP_STORE, 6'd0, 6'(y), 8'($urandom()), 8'($urandom()),
                      rand_samples());

        send_item(OP_STORE, 6'd63, 6'd0, 8'd0, 8'd0, {64{1'b1}});
        send_item(OP_STORE, 6'd0, 6'd0, 8'd255, 8'd255, 64'd0);
        compute(8'd0, 8'd0);
        compute(8'd7, 8'd7);
        compute(8'd255, 8'd255);
        set_sizes(0, 0, 511, 511);
        compute(8'd0, 8'd0);
        compute(8'd255, 8'd255);
        set_sizes(127, 0, 1, 0);
        compute(8'd0, 8'd0);
        compute(8'd255, 8'd0);
        set_sizes(0, 127, 0, 1);
        compute(8'd0, 8'd0);
        compute(8'd0, 8'd255);
        set_sizes(64, 64, 256, 256);
        compute(8'd0, 8'd0);
        compute(8'd63, 8'd63);
        compute(8'd255, 8'd0);
        set_sizes(1, 64, 3, 5);
        compute(8'd0, 8'd4);
        compute(8'd2, 8'd0);
        compute(8'd7, 8'd9);
        set_sizes(63, 1, 64, 1);
        compute(8'd63, 8'd0);
        compute(8'd10, 8'd0);

        for (int p = 0; p < 12; p++)
        begin
            calm = (p == 3);
            random_phase(100, p == 7);
        end
        calm = 0;

        drain();
        repeat (200) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
